// ----- rtl/core/fcst_pkg.sv -----
// Shared types and constants for the fixed-capacity set table.
package fcst_pkg;

  // Widths of the input and result fields.
  localparam int unsigned SlotIdxW   = 4;
  localparam int unsigned ItemCountW = 5;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned InKeyW     = 32;

  // Operation codes carried by each input item.
  typedef enum logic [CmdW-1:0] {
    CmdAdd      = 2'd0,
    CmdRemove   = 2'd1,
    CmdContains = 2'd2,
    CmdClear    = 2'd3
  } cmd_e;

  // Search probe that travels down the row of cells.
  typedef struct packed {
    logic active;
    logic hit;
    logic free;
  } probe_t;

  // Update broadcast to every cell when an item completes.
  typedef struct packed {
    logic add;
    logic remove;
    logic clear;
  } commit_t;

endpackage

// ----- rtl/core/fcst_cell.sv -----
// One slot of the set table: stored key, valid bit and a probe stage.
module fcst_cell import fcst_pkg::*; #(
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  probe_t               probe_i,
  input  logic [IDX_W-1:0]     hit_idx_i,
  input  logic [IDX_W-1:0]     free_idx_i,
  output probe_t               probe_o,
  output logic [IDX_W-1:0]     hit_idx_o,
  output logic [IDX_W-1:0]     free_idx_o,
  input  commit_t              commit_i,
  input  logic [IDX_W-1:0]     commit_idx_i
);

  logic                 valid_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic                 match;
  logic                 sel;
  probe_t               probe_d, probe_q;
  logic [IDX_W-1:0]     hit_idx_d, hit_idx_q;
  logic [IDX_W-1:0]     free_idx_d, free_idx_q;

  // Compare against the searched key and note whether this slot is free.
  assign match = valid_q && (key_q == key_i);
  assign sel   = (commit_idx_i == IDX_W'(CELL_IDX));

  // The lowest slot wins, so an earlier hit or free slot is kept as it is.
  always_comb begin
    probe_d.active = probe_i.active;
    probe_d.hit    = probe_i.hit | match;
    probe_d.free   = probe_i.free | ~valid_q;
    hit_idx_d      = probe_i.hit  ? hit_idx_i  : IDX_W'(CELL_IDX);
    free_idx_d     = probe_i.free ? free_idx_i : IDX_W'(CELL_IDX);
  end

  // Probe stage towards the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
  end

  assign probe_o    = probe_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;

  // Valid bit: set by an add to this slot, cleared by remove or clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (commit_i.clear) begin
      valid_q <= 1'b0;
    end else if (commit_i.add && sel) begin
      valid_q <= 1'b1;
    end else if (commit_i.remove && sel) begin
      valid_q <= 1'b0;
    end
  end

  // Stored key is written only when the slot is claimed.
  always_ff @(posedge clk_i) begin
    if (commit_i.add && sel && !commit_i.clear) begin
      key_q <= key_i;
    end
  end

endmodule

// ----- rtl/core/fixed_capacity_set_table.sv -----
// Top level of the fixed-capacity set table: control, count and result register.
//
//   channel | dir | handshake                 | payload
//   in      | in  | in_valid_i / in_ready_o   | cmd_i, key_i
//   out     | out | out_valid_o / out_ready_i | ok_o, slot_index_o, item_count_o, is_empty_o
//
// One item is handled at a time. A search probe walks the row of CAPACITY cells,
// one cell per cycle, and a new item is accepted only once the result of the
// last one has entered the output register.
// The result is held in an output register; a stalled output holds the update
// of the table until the previous result has been taken.
// Reset empties every slot and clears the count; stored keys are not cleared.
module fixed_capacity_set_table import fcst_pkg::*; #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CmdW-1:0]       cmd_i,
  input  logic [InKeyW-1:0]     key_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  ok_o,
  output logic [SlotIdxW-1:0]   slot_index_o,
  output logic [ItemCountW-1:0] item_count_o,
  output logic                  is_empty_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  state_e               state_q;
  cmd_e                 cmd_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic                 start_q;
  logic                 hit_q, free_q;
  logic [IDX_W-1:0]     hit_idx_q, free_idx_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 out_valid_q;
  logic                 ok_q, ok_d;
  logic [SlotIdxW-1:0]  slot_q;
  logic [IDX_W-1:0]     slot_d;
  logic [ItemCountW-1:0] item_count_q;
  logic                 is_empty_q;
  logic                 in_fire;
  logic                 fire;
  commit_t              commit;

  probe_t               probe_chain    [CAPACITY+1];
  logic [IDX_W-1:0]     hit_idx_chain  [CAPACITY+1];
  logic [IDX_W-1:0]     free_idx_chain [CAPACITY+1];

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign fire       = (state_q == StDone) && (!out_valid_q || out_ready_i);

  // The probe enters the row empty in the cycle after the item is taken.
  assign probe_chain[0].active = start_q;
  assign probe_chain[0].hit    = 1'b0;
  assign probe_chain[0].free   = 1'b0;
  assign hit_idx_chain[0]      = '0;
  assign free_idx_chain[0]     = '0;

  // Row of slot cells.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    fcst_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .IDX_W     (IDX_W),
      .CELL_IDX  (gi)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .key_i        (key_q),
      .probe_i      (probe_chain[gi]),
      .hit_idx_i    (hit_idx_chain[gi]),
      .free_idx_i   (free_idx_chain[gi]),
      .probe_o      (probe_chain[gi+1]),
      .hit_idx_o    (hit_idx_chain[gi+1]),
      .free_idx_o   (free_idx_chain[gi+1]),
      .commit_i     (commit),
      .commit_idx_i (slot_d)
    );
  end

  // Decide the outcome of the item from the finished search.
  always_comb begin
    ok_d    = 1'b0;
    slot_d  = '0;
    count_d = count_q;
    commit  = '0;
    case (cmd_q)
      CmdAdd: begin
        if (!hit_q && free_q) begin
          ok_d    = 1'b1;
          slot_d  = free_idx_q;
          count_d = count_q + CNT_W'(1);
        end
        commit.add = fire && ok_d;
      end
      CmdRemove: begin
        if (hit_q) begin
          ok_d    = 1'b1;
          slot_d  = hit_idx_q;
          count_d = (count_q != '0) ? count_q - CNT_W'(1) : count_q;
        end
        commit.remove = fire && ok_d;
      end
      CmdContains: begin
        if (hit_q) begin
          ok_d   = 1'b1;
          slot_d = hit_idx_q;
        end
      end
      CmdClear: begin
        ok_d         = 1'b1;
        count_d      = '0;
        commit.clear = fire;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Sequencer, count and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      start_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= in_fire;
      // A new result takes the register; otherwise a taken result leaves it.
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            state_q <= StScan;
          end
        end
        StScan: begin
          if (probe_chain[CAPACITY].active) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (fire) begin
            count_q <= count_d;
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Item and search payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_e'(cmd_i);
      key_q <= KEY_WIDTH'(key_i);
    end
    if (state_q == StScan && probe_chain[CAPACITY].active) begin
      hit_q      <= probe_chain[CAPACITY].hit;
      free_q     <= probe_chain[CAPACITY].free;
      hit_idx_q  <= hit_idx_chain[CAPACITY];
      free_idx_q <= free_idx_chain[CAPACITY];
    end
    if (fire) begin
      ok_q         <= ok_d;
      slot_q       <= SlotIdxW'(slot_d);
      item_count_q <= ItemCountW'(count_d);
      is_empty_q   <= (count_d == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign slot_index_o = slot_q;
  assign item_count_o = item_count_q;
  assign is_empty_o   = is_empty_q;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the fixed-capacity set table.
`timescale 1ns / 100ps

module tb;
  import fcst_pkg::*;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned KEY_WIDTH  = 32;
  localparam int unsigned POOL_SIZE  = 24;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned DRAIN_WAIT = CAPACITY + 8;
  localparam int unsigned REPORT_CAP = 50;

  // Expected contents of one result item.
  typedef struct packed {
    logic                  ok;
    logic [SlotIdxW-1:0]   slot;
    logic [ItemCountW-1:0] count;
    logic                  empty;
  } set_result_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [CmdW-1:0]       cmd_i        = CmdContains;
  logic [InKeyW-1:0]     key_i        = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic                  ok_o;
  logic [SlotIdxW-1:0]   slot_index_o;
  logic [ItemCountW-1:0] item_count_o;
  logic                  is_empty_o;

  // Shadow copy of the table, updated as each item is accepted.
  logic [InKeyW-1:0] shadow_keys [CAPACITY];
  logic              shadow_live [CAPACITY];
  int unsigned       shadow_total;

  set_result_t       pending_results [$];
  logic [InKeyW-1:0] key_pool [POOL_SIZE];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_rx       = 1'b0;
  int unsigned cycle_count   = 0;
  int unsigned error_total   = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned full_rejects  = 0;
  int unsigned dup_rejects   = 0;
  int unsigned lookup_hits   = 0;

  fixed_capacity_set_table #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ok_o         (ok_o),
    .slot_index_o (slot_index_o),
    .item_count_o (item_count_o),
    .is_empty_o   (is_empty_o)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: a correct run finishes far inside this many cycles.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (!rst_ni || hold_rx) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (error_total < REPORT_CAP) begin
      $display("Mismatch at cycle %0d on %s: expected %0d, got %0d.",
               cycle_count, what, want, got);
    end
    error_total++;
  endtask

  // Works out the result of one item and applies it to the shadow table.
  function automatic set_result_t shadow_apply(input cmd_e op,
                                               input logic [InKeyW-1:0] k);
    set_result_t res;
    int          hit;
    int          vacant;
    res    = '0;
    hit    = -1;
    vacant = -1;
    // Scan from the top so that the lowest matching and lowest free slot win.
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (shadow_live[i] && shadow_keys[i] == k) hit = i;
      if (!shadow_live[i]) vacant = i;
    end
    case (op)
      CmdAdd: begin
        if (hit < 0 && vacant >= 0) begin
          shadow_keys[vacant] = k;
          shadow_live[vacant] = 1'b1;
          shadow_total++;
          res.ok   = 1'b1;
          res.slot = vacant[SlotIdxW-1:0];
        end
      end
      CmdRemove: begin
        if (hit >= 0) begin
          shadow_live[hit] = 1'b0;
          shadow_total--;
          res.ok   = 1'b1;
          res.slot = hit[SlotIdxW-1:0];
        end
      end
      CmdContains: begin
        if (hit >= 0) begin
          res.ok   = 1'b1;
          res.slot = hit[SlotIdxW-1:0];
        end
      end
      default: begin
        for (int i = 0; i < CAPACITY; i++) shadow_live[i] = 1'b0;
        shadow_total = 0;
        res.ok       = 1'b1;
      end
    endcase
    res.count = shadow_total[ItemCountW-1:0];
    res.empty = (shadow_total == 0);
    return res;
  endfunction

  // Offers one item, waits for it to be taken and records its expected result.
  // Valid is left high on return so that a following item can go back to back.
  task automatic offer_item(input cmd_e op, input logic [InKeyW-1:0] k);
    set_result_t res;
    logic        was_full;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= op;
    key_i      <= k;
    do @(posedge clk_i); while (!in_ready_o);
    was_full        = (shadow_total == CAPACITY);
    res             = shadow_apply(op, k);
    pending_results = {pending_results, res};
    items_sent++;
    if (op == CmdAdd && !res.ok) begin
      if (was_full) full_rejects++;
      else dup_rejects++;
    end
    if ((op == CmdRemove || op == CmdContains) && res.ok) lookup_hits++;
  endtask

  // Compares each taken result with the oldest outstanding expectation.
  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (ok_o !== want.ok) begin
          report_mismatch("ok", 32'(want.ok), 32'(ok_o));
        end
        if (slot_index_o !== want.slot) begin
          report_mismatch("slot index", 32'(want.slot), 32'(slot_index_o));
        end
        if (item_count_o !== want.count) begin
          report_mismatch("item count", 32'(want.count), 32'(item_count_o));
        end
        if (is_empty_o !== want.empty) begin
          report_mismatch("empty flag", 32'(want.empty), 32'(is_empty_o));
        end
      end
    end
  end

  // Random operation, biased towards adds and lookups so the table often fills.
  function automatic cmd_e pick_cmd();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return CmdAdd;
    if (r < 68) return CmdRemove;
    if (r < 98) return CmdContains;
    return CmdClear;
  endfunction

  // Key choice: mostly a key that is present or one from a small reused pool,
  // so that hits and duplicates are common; the rest is fully random.
  function automatic logic [InKeyW-1:0] pick_key();
    int          live_idx [$];
    int unsigned r;
    for (int i = 0; i < CAPACITY; i++) begin
      if (shadow_live[i]) live_idx = {live_idx, i};
    end
    r = $urandom_range(99);
    if (r < 50 && live_idx.size() != 0) begin
      return shadow_keys[live_idx[$urandom_range(live_idx.size() - 1)]];
    end
    if (r < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // Extreme keys, every operation and every rejection case.
  task automatic test_directed();
    offer_item(CmdContains, 32'h0000_0000);   // lookup in an empty table
    offer_item(CmdAdd,      32'h0000_0000);
    offer_item(CmdAdd,      32'hFFFF_FFFF);
    offer_item(CmdAdd,      32'h0000_0000);   // duplicate add
    offer_item(CmdContains, 32'hFFFF_FFFF);
    offer_item(CmdRemove,   32'h0000_0000);
    offer_item(CmdRemove,   32'h0000_0000);   // remove with no match
    offer_item(CmdAdd,      32'hA5A5_5A5A);   // reuses the freed lowest slot
    // Fill the remaining slots with walking-one keys.
    for (int i = 0; i < CAPACITY - 2; i++) begin
      offer_item(CmdAdd, 32'h1 << (i + 1));
    end
    offer_item(CmdAdd,      32'h8000_0001);   // add to a full table
    offer_item(CmdClear,    32'h0000_0000);
    offer_item(CmdContains, 32'hFFFF_FFFF);   // key kept but no longer valid
  endtask

  // Random traffic with the given idle rates on each side.
  task automatic test_random_traffic(input int unsigned n_items,
                                     input int unsigned tx_idle,
                                     input int unsigned rx_idle);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(49) == 0) key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom();
      offer_item(pick_cmd(), pick_key());
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_rx <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
      begin
        for (int n = 0; n < 30; n++) begin
          offer_item((n < 20) ? CmdAdd : pick_cmd(), pick_key());
        end
      end
    join
  endtask

  // Test sequence.
  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_keys[i] = '0;
      shadow_live[i] = 1'b0;
    end
    shadow_total = 0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 8;
    recv_idle_pct = 61;
    test_directed();
    test_random_traffic(360, 8, 61);
    test_random_traffic(360, 61, 8);
    test_random_traffic(360, 0, 0);
    test_output_stall();
    in_valid_i <= 1'b0;

    // Let every outstanding result arrive, then watch for stray ones.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d items and checked %0d results over %0d cycles.",
             items_sent, results_seen, cycle_count);
    $display("Adds refused: %0d on a full table, %0d as duplicates; %0d lookups hit.",
             full_rejects, dup_rejects, lookup_hits);
    if (error_total == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
